// ===== rtl/point_in_triangle_test_macros.svh =====
`ifndef POINT_IN_TRIANGLE_TEST_MACROS_SVH
`define POINT_IN_TRIANGLE_TEST_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PIT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PIT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pit_pkg.sv =====
`default_nettype none

package pit_pkg;

    localparam int CW      = 16;                  // coordinate width
    localparam int NFIELD  = 12;
    localparam int TDATA_W = ((NFIELD * CW + 7) / 8) * 8;
    localparam int OUT_W   = 8;

    localparam int DW  = CW + 1;                  // coordinate difference
    localparam int PW  = 2 * DW;                  // cross product term
    localparam int NW  = PW + 1;                  // cross product component
    localparam int LW  = (NW + 1) / 2;            // low slice, unsigned
    localparam int HW  = NW - LW;                 // high slice, signed
    localparam int HHW = 2 * HW;
    localparam int HLW = HW + LW + 1;
    localparam int LLW = 2 * LW;
    localparam int SW  = 2 * NW + 2;              // dot product sum

    localparam int NSTG = 6;

    typedef logic signed [CW-1:0]  coord_t;
    typedef logic signed [DW-1:0]  diff_t;
    typedef logic signed [PW-1:0]  prod_t;
    typedef logic signed [NW-1:0]  crs_t;
    typedef logic signed [HHW-1:0] hh_t;
    typedef logic signed [HLW-1:0] hl_t;
    typedef logic        [LLW-1:0] ll_t;
    typedef logic signed [SW-1:0]  sum_t;

    typedef struct packed {
        logic [NSTG-1:0] en;
    } ctl_t;

    // Vertex order in tdata: A, B, C, P.
    // Difference vectors: AB, BC, CA, AP, BP, CP.
    localparam int MIN_IDX [6] = '{1, 2, 0, 3, 3, 3};
    localparam int SUB_IDX [6] = '{0, 1, 2, 0, 1, 2};

    // Cross products: AB x BC (normal), AB x AP, BC x BP, CA x CP.
    localparam int CU_IDX [4] = '{0, 0, 1, 2};
    localparam int CV_IDX [4] = '{1, 3, 4, 5};

    localparam int NXT [3] = '{1, 2, 0};
    localparam int PRV [3] = '{2, 0, 1};

endpackage

`default_nettype wire

// ===== rtl/point_in_triangle_test.sv =====
// channel   dir  handshake               tdata (lsb first)
// s_axis    in   tvalid/tready/tdata     ax ay az bx by bz cx cy cz px py pz, 16b each
// m_axis    out  tvalid/tready/tdata     inside_res, 7 zero bits
//
// Six register stages; one transfer per cycle sustained while m_axis_tready stays high.
// Stages: differences, products, cross, partial products, full products, sign.
// Each stage loads when empty or when the next stage loads, so bubbles close up
// and a stalled output holds only the stages behind it that are full.
// rst_n clears the stage valid bits only.
`default_nettype none

`include "point_in_triangle_test_macros.svh"

module point_in_triangle_test
    import pit_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [TDATA_W-1:0] s_axis_tdata,   // ax ay az bx by bz cx cy cz px py pz
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [OUT_W-1:0]        m_axis_tdata    // inside_res, zero fill
);

    ctl_t            ctl;
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic            in_tri;

    always_comb
    begin
        ctl.en[NSTG-1] = ~v_reg[NSTG-1] | m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            ctl.en[k] = ~v_reg[k] | ctl.en[k + 1];
        end
    end

    always_comb
    begin
        v_next[0] = ctl.en[0] ? s_axis_tvalid : v_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            v_next[k] = ctl.en[k] ? v_reg[k - 1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    pit_datapath u_datapath
    (
        .clk     (clk),
        .ctl     (ctl),
        .in_data (s_axis_tdata),
        .in_tri  (in_tri)
    );

    assign s_axis_tready = ctl.en[0];
    assign m_axis_tvalid = v_reg[NSTG-1];
    assign m_axis_tdata  = {(OUT_W - 1)'(0), in_tri};

    `PIT_ASSERT_NOW(a_full_when_not_ready, !s_axis_tready, (&v_reg) && !m_axis_tready, "input stalled with a free stage")
    `PIT_ASSERT_NEXT(a_accept_fills_first, s_axis_tvalid && s_axis_tready, v_reg[0], "accepted transfer lost at stage one")
    `PIT_ASSERT_NEXT(a_output_refills, m_axis_tready && v_reg[NSTG-2], m_axis_tvalid, "waiting result did not advance to output")

endmodule

`default_nettype wire

// ===== rtl/pit_datapath.sv =====
`default_nettype none

module pit_datapath
    import pit_pkg::*;
(
    input  wire logic               clk,
    input  wire ctl_t               ctl,
    input  wire logic [TDATA_W-1:0] in_data,
    output logic                    in_tri
);

    coord_t crd [4][3];
    diff_t  d_next [6][3];
    diff_t  d_reg  [6][3];
    prod_t  m_next [4][3][2];
    prod_t  m_reg  [4][3][2];
    crs_t   x_next [4][3];
    crs_t   x_reg  [4][3];
    hh_t    hh_next [3][3];
    hh_t    hh_reg  [3][3];
    hl_t    hl_next [3][3];
    hl_t    hl_reg  [3][3];
    hl_t    lh_next [3][3];
    hl_t    lh_reg  [3][3];
    ll_t    ll_next [3][3];
    ll_t    ll_reg  [3][3];
    sum_t   q_next [3][3];
    sum_t   q_reg  [3][3];
    sum_t   s_sum  [3];
    logic   inside_next;
    logic   inside_reg;

    // stage 1: edge and point vectors
    always_comb
    begin
        for (int v = 0; v < 4; v++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                crd[v][k] = coord_t'(in_data[(3 * v + k) * CW +: CW]);
            end
        end
        for (int i = 0; i < 6; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_next[i][k] = DW'(crd[MIN_IDX[i]][k]) - DW'(crd[SUB_IDX[i]][k]);
            end
        end
    end

    // stage 2: cross product terms
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                m_next[c][k][0] = PW'(d_reg[CU_IDX[c]][NXT[k]])
                                * PW'(d_reg[CV_IDX[c]][PRV[k]]);
                m_next[c][k][1] = PW'(d_reg[CU_IDX[c]][PRV[k]])
                                * PW'(d_reg[CV_IDX[c]][NXT[k]]);
            end
        end
    end

    // stage 3: cross product components
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                x_next[c][k] = NW'(m_reg[c][k][0]) - NW'(m_reg[c][k][1]);
            end
        end
    end

    // stage 4: split dot product multiplies into partial products
    always_comb
    begin
        logic signed [HW-1:0] ah;
        logic signed [HW-1:0] bh;
        logic        [LW-1:0] al;
        logic        [LW-1:0] bl;
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ah = $signed(x_reg[j + 1][k][NW-1:LW]);
                al = x_reg[j + 1][k][LW-1:0];
                bh = $signed(x_reg[0][k][NW-1:LW]);
                bl = x_reg[0][k][LW-1:0];
                hh_next[j][k] = hh_t'(ah) * hh_t'(bh);
                hl_next[j][k] = hl_t'(ah) * hl_t'($signed({1'b0, bl}));
                lh_next[j][k] = hl_t'($signed({1'b0, al})) * hl_t'(bh);
                ll_next[j][k] = ll_t'(al) * ll_t'(bl);
            end
        end
    end

    // stage 5: full products
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                q_next[j][k] = (sum_t'(hh_reg[j][k]) <<< (2 * LW))
                             + ((sum_t'(hl_reg[j][k]) + sum_t'(lh_reg[j][k])) <<< LW)
                             + sum_t'(ll_reg[j][k]);
            end
        end
    end

    // stage 6: dot product signs
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            s_sum[j] = q_reg[j][0] + q_reg[j][1] + q_reg[j][2];
        end
        inside_next = ~s_sum[0][SW-1] & ~s_sum[1][SW-1] & ~s_sum[2][SW-1];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            d_reg <= d_next;
        end
        if (ctl.en[1])
        begin
            m_reg <= m_next;
        end
        if (ctl.en[2])
        begin
            x_reg <= x_next;
        end
        if (ctl.en[3])
        begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
        end
        if (ctl.en[4])
        begin
            q_reg <= q_next;
        end
        if (ctl.en[5])
        begin
            inside_reg <= inside_next;
        end
    end

    assign in_tri = inside_reg;

endmodule

`default_nettype wire
